[rtl/upd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and helpers of the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	localparam int         PADDR_W         = 3;
	localparam logic [0:0] REG_MAX_OUT_LEN = 1'b0;
	localparam logic [15:0] MAX_LEN_RESET  = 16'd1023;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// up to three decoded bytes per request, then an optional terminator
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            eos;
	} upd_entry_t;

	function automatic logic is_hex(input logic [7:0] ch);
		logic r;
		r = ((ch >= 8'h30) && (ch <= 8'h39)) ||
			((ch >= 8'h61) && (ch <= 8'h66)) ||
			((ch >= 8'h41) && (ch <= 8'h46));
		return r;
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] ch);
		logic [3:0] r;
		if (ch <= 8'h39) begin
			r = ch[3:0];
		end else begin
			r = ch[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

[rtl/upd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_in_if
// Encoded byte channel: valid/ready handshake with the byte and its end mark.
// ----------------------------------------------------------------------------
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source(output valid, output in_byte, output last_byte, input ready);
	modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

[rtl/upd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_out_if
// Decoded result channel: valid/ready handshake with byte and status flags.
// ----------------------------------------------------------------------------
interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_string;

	modport source(output valid, output out_byte, output byte_valid,
		output end_of_string, input ready);
	modport sink(input valid, input out_byte, input byte_valid,
		input end_of_string, output ready);
endinterface

[rtl/upd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks the escape phase and builds the list of
// candidate decoded bytes and the terminator flag for each request.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic                clk,
	input  logic                arst_n,
	upd_in_if.sink              in_ch,
	input  logic                q_full,
	output logic                push,
	output upd_pkg::upd_entry_t push_entry
);

	logic [1:0] phase_q;
	logic [7:0] first_q;
	logic [1:0] phase_d;
	logic [7:0] first_d;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	always_comb begin
		logic [7:0] ch;
		logic       nz;
		logic       hx;
		logic       fresh;
		logic [1:0] n;
		logic [2:0][7:0] b;
		logic [1:0] ph;
		logic [7:0] f;
		ch    = in_ch.in_byte;
		nz    = (ch != upd_pkg::CH_NUL);
		hx    = upd_pkg::is_hex(ch);
		fresh = 1'b0;
		n     = 2'd0;
		b     = '0;
		ph    = phase_q;
		f     = first_q;
		if (nz) begin
			fresh = 1'b1;
			if (ph == upd_pkg::PH_PCT) begin
				if (hx) begin
					f     = ch;
					ph    = upd_pkg::PH_DIGIT;
					fresh = 1'b0;
				end else begin
					b[n] = upd_pkg::CH_PCT;
					n    = n + 2'd1;
					ph   = upd_pkg::PH_IDLE;
				end
			end else if (ph == upd_pkg::PH_DIGIT) begin
				if (hx) begin
					b[n]  = {upd_pkg::hex_nib(f), upd_pkg::hex_nib(ch)};
					n     = n + 2'd1;
					ph    = upd_pkg::PH_IDLE;
					f     = upd_pkg::CH_NUL;
					fresh = 1'b0;
				end else begin
					b[n] = upd_pkg::CH_PCT;
					n    = n + 2'd1;
					b[n] = f;
					n    = n + 2'd1;
					ph   = upd_pkg::PH_IDLE;
				end
			end
			if (fresh) begin
				if (ch == upd_pkg::CH_PCT) begin
					ph = upd_pkg::PH_PCT;
				end else if (ch == upd_pkg::CH_PLUS) begin
					b[n] = upd_pkg::CH_SPACE;
					n    = n + 2'd1;
				end else begin
					b[n] = ch;
					n    = n + 2'd1;
				end
			end
		end
		push_entry.eos = !nz || in_ch.last_byte;
		if (push_entry.eos) begin
			// flush a cut escape literally
			if (ph != upd_pkg::PH_IDLE) begin
				b[n] = upd_pkg::CH_PCT;
				n    = n + 2'd1;
				if (ph == upd_pkg::PH_DIGIT) begin
					b[n] = f;
					n    = n + 2'd1;
				end
			end
			ph = upd_pkg::PH_IDLE;
			f  = upd_pkg::CH_NUL;
		end
		push_entry.bytes = b;
		push_entry.cnt   = n;
		phase_d          = ph;
		first_d          = f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			first_q <= upd_pkg::CH_NUL;
		end else if (push) begin
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

endmodule

[rtl/upd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue
// Small register queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module upd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upd_pkg::upd_entry_t push_entry,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output upd_pkg::upd_entry_t head
);

	upd_pkg::upd_entry_t             mem_q [upd_pkg::QDEPTH];
	logic [upd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [upd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [upd_pkg::QPTR_W:0]        count_q;

	assign full       = (count_q == (upd_pkg::QPTR_W+1)'(upd_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (upd_pkg::QPTR_W+1)'(upd_pkg::QDEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

[rtl/upd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back
// Walks each queued request one result per cycle while the output is free,
// applies the output length limit and drives the registered result channel.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         max_out_len,
	input  logic                head_valid,
	input  upd_pkg::upd_entry_t head,
	output logic                pop,
	upd_out_if.source           out_ch
);

	logic [1:0]  k_q;
	logic [15:0] count_q;
	logic        skip_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q;
	logic        eos_q;

	logic        out_free;
	logic        pass;
	logic        is_byte;
	logic        adv;
	logic        load;
	logic        load_term;

	assign out_free = !out_valid_q || out_ch.ready;
	assign pass     = !skip_q && (count_q < max_out_len);
	assign is_byte  = (k_q < head.cnt);

	always_comb begin
		adv       = 1'b0;
		load      = 1'b0;
		load_term = 1'b0;
		pop       = 1'b0;
		if (head_valid) begin
			if (is_byte) begin
				if (pass) begin
					adv  = out_free;
					load = out_free;
				end else begin
					adv = 1'b1;
				end
				if (adv && !head.eos && (k_q == head.cnt - 2'd1)) begin
					pop = 1'b1;
				end
			end else if (head.eos) begin
				load      = out_free;
				load_term = out_free;
				pop       = out_free;
			end else begin
				pop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			count_q     <= '0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				k_q <= 2'd0;
			end else if (adv) begin
				k_q <= k_q + 2'd1;
			end
			if (load_term) begin
				count_q <= '0;
				skip_q  <= 1'b0;
			end else if (adv && pass) begin
				count_q <= count_q + 16'd1;
			end else if (adv) begin
				skip_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= load_term ? upd_pkg::CH_NUL : head.bytes[k_q];
			byte_valid_q <= !load_term;
			eos_q        <= load_term;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = out_byte_q;
	assign out_ch.byte_valid    = byte_valid_q;
	assign out_ch.end_of_string = eos_q;

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_term |=> (count_q == '0) && !skip_q)
		else $error("terminator did not clear string state");

	a_term_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (byte_valid_q != eos_q))
		else $error("result is neither byte nor terminator");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (k_q <= head.cnt))
		else $error("slot index past request");

endmodule

[rtl/url_percent_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// URL percent decoder with APB limit register and valid/ready byte channels.
// ----------------------------------------------------------------------------
// One encoded byte is accepted per cycle while the four-entry request queue
// has room. The front decodes %XY escapes and '+' in the accept cycle and
// queues up to three decoded bytes plus an optional terminator per byte; the
// back emits one result per cycle while the output register is free, and each
// result passes through the queue and the output register after acceptance.
// Dropped bytes past max_out_len (APB address 0, reset 1023) are still walked
// by the back but give no result. A zero byte or last_byte ends the string
// with a terminator result and clears the per-string state.
module url_percent_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [upd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	upd_in_if.sink                      in_ch,
	upd_out_if.source                   out_ch
);

	logic [15:0]         max_out_len_q;
	logic                reg_hit;
	logic                q_full;
	logic                push;
	upd_pkg::upd_entry_t push_entry;
	logic                pop;
	logic                head_valid;
	upd_pkg::upd_entry_t head;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[upd_pkg::PADDR_W-1:2] == upd_pkg::REG_MAX_OUT_LEN);
	assign prdata  = reg_hit ? {16'd0, max_out_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_len_q <= upd_pkg::MAX_LEN_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			max_out_len_q <= pwdata[15:0];
		end
	end

	upd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	upd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	upd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_out_len (max_out_len_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule
